// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared widths, status codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int HEAP_BYTES_DEF   = 1048576;
   localparam int MAX_BLOCKS_DEF   = 256;
   localparam int HEADER_BYTES_DEF = 24;

   localparam int ADDR_W = 20;
   localparam int SIZE_W = 21;
   localparam int INCR_W = 17;
   localparam logic [INCR_W-1:0] INCR_RESET = 17'd4096;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ZERO    = 2'd1,
      ST_NOSPACE = 2'd2,
      ST_UNKNOWN = 2'd3
   } status_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // one table entry as it travels down the cell row
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
      logic              free;
   } entry_type;

endpackage

// ===== hw/rtl/ffha_cell.sv =====
// ----------------------------------------------------------------------------
// ffha_cell
// One table slot; slots rotate through the row so slot 0 always holds the
// entry under inspection.
// ----------------------------------------------------------------------------
module ffha_cell (
   input  logic                clock,
   input  logic                shift,
   input  logic                load,
   input  ffha_pkg::entry_type load_val,
   input  ffha_pkg::entry_type prev,
   output ffha_pkg::entry_type cur
);
   import ffha_pkg::*;

   entry_type ent_ff, ent_in;

   always_comb begin
      ent_in = ent_ff;
      if (load) begin
         ent_in = load_val;
      end else if (shift) begin
         ent_in = prev;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign cur = ent_ff;
endmodule

// ===== hw/rtl/ffha_ring.sv =====
// ----------------------------------------------------------------------------
// ffha_ring
// Circular row of MAX_BLOCKS cells. Slot 0 is the head; a shift moves every
// entry one slot toward the head and the head entry (possibly edited) back
// to the tail.
// ----------------------------------------------------------------------------
module ffha_ring #(
   parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
   input  logic                clock,
   input  logic                shift,
   input  ffha_pkg::entry_type head_in,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  ffha_pkg::entry_type wr_val,
   output ffha_pkg::entry_type head
);
   import ffha_pkg::*;

   entry_type cells [MAX_BLOCKS];

   genvar g;
   generate
      for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
         entry_type nb;
         if (g == MAX_BLOCKS-1) begin : g_tail
            assign nb = head_in;
         end else begin : g_mid
            assign nb = cells[g+1];
         end
         ffha_cell u_cell (
            .clock    (clock),
            .shift    (shift),
            .load     (wr_en && (wr_idx == IDX_W'(g))),
            .load_val (wr_val),
            .prev     (nb),
            .cur      (cells[g])
         );
      end
   endgenerate

   assign head = cells[0];
endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with a bump break over a rotating cell row.
// ----------------------------------------------------------------------------
// A request that scans (every alloc past the zero check, every nonzero free)
// walks the full rotation of the cell row in S_SCAN before S_DONE raises
// rsp_tvalid; zero-size alloc and null free go straight to S_DONE.
// One request at a time; req_tready returns the cycle after the result is
// taken. Synchronous reset empties the table and break.
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // req_size[20:0], free_addr[40:21], zeros
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[1:0], payload_addr[21:2],
                                    // heap_used[42:22], zeros
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data  // min_increment
);
   import ffha_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = IDX_W + 1;
   localparam int W     = 32;

   state_type state_ff, state_in;
   logic [INCR_W-1:0] incr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0] brk_ff, brk_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic              op_ff;
   logic [W-1:0]      need_ff;
   logic [ADDR_W-1:0] faddr_ff;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] hit_start_ff, hit_start_in;
   logic [CNT_W-1:0]  cut_cnt_ff, cut_cnt_in;
   logic [SIZE_W-1:0] cut_brk_ff, cut_brk_in;
   status_type        st_ff, st_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              out_v_ff;

   entry_type head, head_mod, wr_val;
   logic      shift, wr_en;
   logic [IDX_W-1:0] wr_idx;

   ffha_ring #(.MAX_BLOCKS(MAX_BLOCKS), .IDX_W(IDX_W)) u_ring (
      .clock(clock), .shift(shift), .head_in(head_mod), .wr_en(wr_en),
      .wr_idx(wr_idx), .wr_val(wr_val), .head(head)
   );

   logic accept;
   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   assign accept     = req_tvalid && req_tready;

   logic [W-1:0] rsize, grow, brk_w;
   logic         in_range, hit_now;
   always_comb begin
      rsize    = W'(req_tdata[20:0]);
      in_range = (pos_ff < count_ff);
      hit_now  = 1'b0;
      if (in_range) begin
         if (op_ff == OP_ALLOC) begin
            hit_now = head.free && (W'(head.size) >= need_ff);
         end else begin
            hit_now = (W'(head.start) + W'(HEADER_BYTES)) == W'(faddr_ff);
         end
      end
      grow = W'(HEADER_BYTES) + need_ff;
      if (grow < W'(incr_ff)) grow = W'(incr_ff);
      brk_w = W'(brk_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            if ((req_tuser == OP_ALLOC && rsize == '0) ||
                (req_tuser == OP_FREE && req_tdata[40:21] == '0)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: if (pos_ff == CNT_W'(MAX_BLOCKS-1)) state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath / outputs
   always_comb begin
      shift        = 1'b0;
      head_mod     = head;
      wr_en        = 1'b0;
      wr_idx       = '0;
      wr_val       = '0;
      pos_in       = pos_ff;
      found_in     = found_ff;
      hit_start_in = hit_start_ff;
      cut_cnt_in   = cut_cnt_ff;
      cut_brk_in   = cut_brk_ff;
      count_in     = count_ff;
      brk_in       = brk_ff;
      st_in        = st_ff;
      addr_in      = addr_ff;
      case (state_ff)
         S_IDLE: begin
            pos_in     = '0;
            found_in   = 1'b0;
            cut_cnt_in = '0;
            cut_brk_in = '0;
            if (accept) begin
               st_in   = ST_OK;
               addr_in = '0;
               if (req_tuser == OP_ALLOC && rsize == '0) st_in = ST_ZERO;
            end
         end
         S_SCAN: begin
            shift  = 1'b1;
            pos_in = pos_ff + 1'b1;
            if (hit_now && !found_ff) begin
               found_in     = 1'b1;
               hit_start_in = head.start;
               head_mod.free = (op_ff == OP_FREE);
            end
            // end of the last busy entry: everything past it is a free tail
            if (in_range && !head_mod.free) begin
               cut_cnt_in = pos_ff + 1'b1;
               cut_brk_in = SIZE_W'(W'(head.start) + W'(HEADER_BYTES) + W'(head.size));
            end
            if (pos_ff == CNT_W'(MAX_BLOCKS-1)) begin
               if (op_ff == OP_ALLOC) begin
                  if (found_ff || hit_now) begin
                     addr_in = ADDR_W'(W'(hit_now && !found_ff ? head.start : hit_start_ff)
                                       + W'(HEADER_BYTES));
                  end else if (count_ff == CNT_W'(MAX_BLOCKS) ||
                               brk_w + grow > W'(HEAP_BYTES)) begin
                     st_in = ST_NOSPACE;
                  end else begin
                     wr_en    = 1'b1;
                     wr_idx   = count_ff[IDX_W-1:0];
                     wr_val.start = ADDR_W'(brk_w);
                     wr_val.size  = ADDR_W'(grow - W'(HEADER_BYTES));
                     wr_val.free  = 1'b0;
                     count_in = count_ff + 1'b1;
                     addr_in  = ADDR_W'(brk_w + W'(HEADER_BYTES));
                     brk_in   = SIZE_W'(brk_w + grow);
                  end
               end else if (!(found_ff || hit_now)) begin
                  st_in = ST_UNKNOWN;
               end else begin
                  count_in = cut_cnt_in;
                  if (cut_cnt_in != count_ff) brk_in = cut_brk_in;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         incr_ff  <= INCR_RESET;
         count_ff <= '0;
         brk_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         brk_ff   <= brk_in;
         if (csr_wr_en) incr_ff <= csr_wr_data;
         if (state_ff == S_DONE) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      hit_start_ff <= hit_start_in;
      cut_cnt_ff   <= cut_cnt_in;
      cut_brk_ff   <= cut_brk_in;
      st_ff        <= st_in;
      addr_ff      <= addr_in;
      if (accept) begin
         op_ff    <= req_tuser;
         need_ff  <= (W'(req_tdata[20:0]) + W'(7)) & ~W'(7);
         faddr_ff <= req_tdata[40:21];
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'd0, brk_ff, addr_ff, st_ff};
endmodule

// ===== verif/first_fit_heap_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives alloc and free requests into the heap allocator and checks every
// response word against a behavioral model of the block table and break.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
   import ffha_pkg::*;

   localparam int HEAP  = HEAP_BYTES_DEF;
   localparam int NBLK  = MAX_BLOCKS_DEF;
   localparam int HDR   = HEADER_BYTES_DEF;
   localparam int LIMIT = 4000000;

   typedef struct {
      status_type      status;
      logic [19:0]     addr;
      logic [20:0]     used;
   } rsp_type;

   typedef struct {
      logic        op;
      logic [20:0] size;
      logic [19:0] faddr;
      logic        known;
      status_type  status;
      logic [19:0] addr;
      logic [20:0] used;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;

   first_fit_heap_allocator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // allocator model
   logic [19:0] blk_start [NBLK];
   logic [19:0] blk_size  [NBLK];
   logic        blk_free  [NBLK];
   int          blk_count;
   longint      brk;
   longint      incr;

   rsp_type     expected_q [$];
   int          errors = 0;
   int          cycles = 0;
   bit          hold_off = 1'b0;

   function automatic rsp_type heap_apply(logic op, logic [20:0] size, logic [19:0] fa);
      rsp_type r;
      longint need, grow;
      bit hit;
      r.status = ST_OK;
      r.addr = '0;
      hit = 1'b0;
      if (op == OP_ALLOC) begin
         if (size == 0) begin
            r.status = ST_ZERO;
         end else begin
            need = (longint'(size) + 7) & ~longint'(7);
            for (int i = 0; i < blk_count && !hit; i++) begin
               if (blk_free[i] && longint'(blk_size[i]) >= need) begin
                  blk_free[i] = 1'b0;
                  r.addr = 20'(longint'(blk_start[i]) + HDR);
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               grow = HDR + need;
               if (grow < incr) grow = incr;
               if (blk_count >= NBLK || brk + grow > HEAP) begin
                  r.status = ST_NOSPACE;
               end else begin
                  blk_start[blk_count] = brk[19:0];
                  blk_size[blk_count]  = 20'(grow - HDR);
                  blk_free[blk_count]  = 1'b0;
                  blk_count++;
                  r.addr = 20'(brk + HDR);
                  brk += grow;
               end
            end
         end
      end else if (fa != 0) begin
         for (int i = 0; i < blk_count && !hit; i++) begin
            if (longint'(blk_start[i]) + HDR == longint'(fa)) begin
               blk_free[i] = 1'b1;
               hit = 1'b1;
            end
         end
         if (!hit) begin
            r.status = ST_UNKNOWN;
         end else begin
            while (blk_count > 0 && blk_free[blk_count-1]) begin
               grow = HDR + longint'(blk_size[blk_count-1]);
               brk = (brk >= grow) ? brk - grow : 0;
               blk_count--;
            end
         end
      end
      r.used = brk[20:0];
      return r;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: stall pattern, plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 3) != 0) || cycles[9];
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected rsp word %h", rsp_tdata);
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata[1:0] !== e.status || rsp_tdata[21:2] !== e.addr
                || rsp_tdata[42:22] !== e.used) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp st %0d addr %h used %h, got st %0d addr %h used %h",
                     e.status, e.addr, e.used, rsp_tdata[1:0], rsp_tdata[21:2],
                     rsp_tdata[42:22]);
            end
         end
      end
   end

   task automatic send_req(logic op, logic [20:0] size, logic [19:0] fa, bit known,
                           rsp_type fixed);
      rsp_type r;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, fa, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = heap_apply(op, size, fa);
      if (known && (r.status !== fixed.status || r.addr !== fixed.addr
                    || r.used !== fixed.used)) begin
         errors++;
         $display("directed row disagrees with model");
      end
      expected_q.push_back(r);
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (NBLK + 300) @(posedge clock);
   endtask

   task automatic write_incr(logic [16:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      incr = v;
      @(posedge clock);
   endtask

   function automatic logic [19:0] pick_live();
      if (blk_count == 0) return 20'(HDR);
      return 20'(longint'(blk_start[$urandom_range(0, blk_count - 1)]) + HDR);
   endfunction

   task automatic random_phase(int n, int maxsz);
      logic [20:0] sz;
      logic [19:0] fa;
      rsp_type none;
      none = '{ST_OK, '0, '0};
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 19))
            0: send_req(OP_FREE, 21'($urandom), 20'($urandom), 0, none);
            1: send_req(OP_ALLOC, 21'($urandom), 20'($urandom), 0, none);
            2: send_req(OP_FREE, 21'($urandom), 20'd0, 0, none);
            3, 4, 5, 6, 7, 8: begin
               fa = pick_live();
               send_req(OP_FREE, 21'($urandom), fa, 0, none);
            end
            default: begin
               sz = 21'($urandom_range(0, maxsz));
               send_req(OP_ALLOC, sz, 20'($urandom), 0, none);
            end
         endcase
      end
   endtask

   row_type dir_rows [$];

   initial begin
      rsp_type fx;
      blk_count = 0;
      brk = 0;
      incr = 4096;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // op, size, addr, known, status, addr, used
      dir_rows = '{
         '{OP_ALLOC, 21'd0, 20'd0, 1, ST_ZERO, 20'd0, 21'd0},
         '{OP_FREE, 21'd0, 20'd0, 1, ST_OK, 20'd0, 21'd0},
         '{OP_FREE, 21'd0, 20'd24, 1, ST_UNKNOWN, 20'd0, 21'd0},
         '{OP_ALLOC, 21'd1, 20'd0, 1, ST_OK, 20'd24, 21'd4096},
         '{OP_ALLOC, 21'd4072, 20'd0, 1, ST_OK, 20'd4120, 21'd8192},
         '{OP_ALLOC, 21'd5000, 20'd0, 1, ST_OK, 20'd8216, 21'd13216},
         '{OP_FREE, 21'd0, 20'd24, 1, ST_OK, 20'd0, 21'd13216},
         '{OP_FREE, 21'd0, 20'd24, 1, ST_OK, 20'd0, 21'd13216},
         '{OP_ALLOC, 21'd8, 20'd0, 1, ST_OK, 20'd24, 21'd13216},
         '{OP_FREE, 21'd0, 20'd8215, 1, ST_UNKNOWN, 20'd0, 21'd13216},
         '{OP_ALLOC, 21'h1FFFFF, 20'hFFFFF, 1, ST_NOSPACE, 20'd0, 21'd13216},
         '{OP_ALLOC, 21'd1048576, 20'd0, 1, ST_NOSPACE, 20'd0, 21'd13216},
         '{OP_FREE, 21'h1FFFFF, 20'hFFFFF, 1, ST_UNKNOWN, 20'd0, 21'd13216},
         '{OP_FREE, 21'd0, 20'd8216, 1, ST_OK, 20'd0, 21'd8192},
         '{OP_FREE, 21'd0, 20'd4120, 0, ST_OK, 20'd0, 21'd0},
         '{OP_FREE, 21'd0, 20'd24, 0, ST_OK, 20'd0, 21'd0},
         '{OP_ALLOC, 21'd1044456, 20'd0, 0, ST_OK, 20'd0, 21'd0},
         '{OP_ALLOC, 21'd1, 20'd0, 0, ST_OK, 20'd0, 21'd0},
         '{OP_FREE, 21'd0, 20'd24, 0, ST_OK, 20'd0, 21'd0}
      };
      foreach (dir_rows[i]) begin
         fx = '{dir_rows[i].status, dir_rows[i].addr, dir_rows[i].used};
         send_req(dir_rows[i].op, dir_rows[i].size, dir_rows[i].faddr,
                  dir_rows[i].known, fx);
      end
      drain();

      // smallest increment: random small allocs and frees
      write_incr(17'd8);
      random_phase(300, 64);
      drain();
      write_incr(17'h1FFFF);
      random_phase(200, 3000);
      drain();
      write_incr(17'd512);
      fork
         random_phase(400, 4096);
         begin
            repeat (50) @(posedge clock);
            hold_off = 1'b1;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      drain();
      write_incr(17'd65536);
      random_phase(330, 70000);
      drain();

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_cell.sv
hw/rtl/ffha_ring.sv
hw/rtl/first_fit_heap_allocator.sv
verif/first_fit_heap_allocator_tb.sv
